// ===== rtl/hpt_pkg.sv =====
// Shared constants and helpers of the humidity, pressure and temperature compensation block
`timescale 1ns / 1ps
package hpt_pkg;

   localparam int unsigned DIV_BITS = 32;
   localparam int unsigned TFINE_LAT = 5;
   localparam int unsigned PRESS_PRE = 8;
   localparam int unsigned PRESS_POST = 3;
   localparam int unsigned LAT = TFINE_LAT + PRESS_PRE + DIV_BITS + PRESS_POST;
   localparam int unsigned TEMP_DLY = LAT - TFINE_LAT - 1;
   localparam int unsigned HUM_DLY = LAT - TFINE_LAT - 12;

   localparam logic signed [31:0] TEMP_MIN = -32'sd4000;
   localparam logic signed [31:0] TEMP_MAX = 32'sd8500;
   localparam logic [31:0] PRESS_MIN = 32'd30000;
   localparam logic [31:0] PRESS_MAX = 32'd110000;
   localparam logic signed [31:0] HUM_E_MAX = 32'sd419430400;

   typedef enum logic [2:0] {
      CSR_TEMP_CALIB       = 3'd0,
      CSR_PRESS_CALIB_LOW  = 3'd1,
      CSR_PRESS_CALIB_HIGH = 3'd2,
      CSR_PRESS_CALIB_LAST = 3'd3,
      CSR_HUM_CALIB        = 3'd4
   } csr_index_type;

   // truncating signed division by 2^k
   function automatic logic signed [31:0] sdiv_p2(input logic signed [31:0] x,
                                                  input int unsigned k);
      logic [31:0] bias;
      logic signed [31:0] t;
      bias = (32'd1 << k) - 32'd1;
      t = x[31] ? x + $signed(bias) : x;
      return t >>> k;
   endfunction

   function automatic logic signed [31:0] sx16(input logic [15:0] v);
      return $signed({{16{v[15]}}, v});
   endfunction

   function automatic logic signed [31:0] sx12(input logic [11:0] v);
      return $signed({{20{v[11]}}, v});
   endfunction

   function automatic logic signed [31:0] sx8(input logic [7:0] v);
      return $signed({{24{v[7]}}, v});
   endfunction

endpackage

// ===== rtl/hpt_if.sv =====
// Request and response channel interfaces
`timescale 1ns / 1ps
interface hpt_req_if;
   logic        valid;
   logic        ready;
   logic [19:0] raw_temperature;
   logic [19:0] raw_pressure;
   logic [15:0] raw_humidity;
   modport source (output valid, raw_temperature, raw_pressure, raw_humidity, input ready);
   modport sink (input valid, raw_temperature, raw_pressure, raw_humidity, output ready);
endinterface

interface hpt_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [14:0] temp_centidegrees;
   logic [16:0]        pressure_pa;
   logic [16:0]        humidity_q10;
   modport source (output valid, temp_centidegrees, pressure_pa, humidity_q10, input ready);
   modport sink (input valid, temp_centidegrees, pressure_pa, humidity_q10, output ready);
endinterface

// ===== rtl/humidity_pressure_temp_compensation.sv =====
// Top level of the humidity, pressure and temperature compensation pipeline
// Throughput: one item per cycle unless the response channel stalls; the 32-stage pressure divider sets the depth.
// The whole pipeline holds while a result waits on the response channel.
// Synchronous active-high reset clears the valid bits and the calibration registers.
`timescale 1ns / 1ps
module humidity_pressure_temp_compensation
   import hpt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   hpt_req_if.sink     req_chan,
   hpt_rsp_if.source   rsp_chan,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata
);

   logic [47:0] temp_calib_ff;
   logic [63:0] press_calib_low_ff, press_calib_high_ff, hum_calib_ff;
   logic [15:0] press_calib_last_ff;
   logic [LAT-1:0] vld_ff, vld_in;
   logic en;
   logic signed [31:0] tfine;
   logic [19:0] rp_d;
   logic [15:0] rh_d;
   logic signed [14:0] temp_s;
   logic [16:0] press_s, hum_s;
   logic signed [14:0] temp_dly_ff [TEMP_DLY];
   logic [16:0] hum_dly_ff [HUM_DLY];

   assign en = !vld_ff[LAT-1] || rsp_chan.ready;
   assign req_chan.ready = en;
   assign vld_in = {vld_ff[LAT-2:0], req_chan.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_calib_ff <= '0;
         press_calib_low_ff <= '0;
         press_calib_high_ff <= '0;
         press_calib_last_ff <= '0;
         hum_calib_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_TEMP_CALIB: temp_calib_ff <= csr_wdata[47:0];
            CSR_PRESS_CALIB_LOW: press_calib_low_ff <= csr_wdata;
            CSR_PRESS_CALIB_HIGH: press_calib_high_ff <= csr_wdata;
            CSR_PRESS_CALIB_LAST: press_calib_last_ff <= csr_wdata[15:0];
            CSR_HUM_CALIB: hum_calib_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   hpt_temp u_temp (
      .clock           (clock),
      .en              (en),
      .temp_calib      (temp_calib_ff),
      .raw_temperature (req_chan.raw_temperature),
      .raw_pressure    (req_chan.raw_pressure),
      .raw_humidity    (req_chan.raw_humidity),
      .tfine           (tfine),
      .rp_out          (rp_d),
      .rh_out          (rh_d),
      .temp_out        (temp_s)
   );

   hpt_press u_press (
      .clock            (clock),
      .en               (en),
      .press_calib_low  (press_calib_low_ff),
      .press_calib_high (press_calib_high_ff),
      .press_calib_last (press_calib_last_ff),
      .tfine            (tfine),
      .raw_pressure     (rp_d),
      .pressure_out     (press_s)
   );

   hpt_hum u_hum (
      .clock        (clock),
      .en           (en),
      .hum_calib    (hum_calib_ff),
      .tfine        (tfine),
      .raw_humidity (rh_d),
      .humidity_out (hum_s)
   );

   // align the early results with the pressure result
   always_ff @(posedge clock) begin
      if (en) begin
         temp_dly_ff[0] <= temp_s;
         for (int i = 1; i < TEMP_DLY; i++) begin
            temp_dly_ff[i] <= temp_dly_ff[i-1];
         end
         hum_dly_ff[0] <= hum_s;
         for (int i = 1; i < HUM_DLY; i++) begin
            hum_dly_ff[i] <= hum_dly_ff[i-1];
         end
      end
   end

   assign rsp_chan.valid = vld_ff[LAT-1];
   assign rsp_chan.temp_centidegrees = temp_dly_ff[TEMP_DLY-1];
   assign rsp_chan.pressure_pa = press_s;
   assign rsp_chan.humidity_q10 = hum_dly_ff[HUM_DLY-1];

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_chan.valid)
      else $error("response valid after reset");
   a_temp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.temp_centidegrees >= -15'sd4000 &&
                          rsp_chan.temp_centidegrees <= 15'sd8500))
      else $error("temperature out of range");
   a_press_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.pressure_pa >= 17'd30000 &&
                          rsp_chan.pressure_pa <= 17'd110000))
      else $error("pressure out of range");
   a_hum_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.humidity_q10 <= 17'd102400))
      else $error("humidity out of range");

endmodule

// ===== rtl/hpt_temp.sv =====
// Temperature path: fine temperature term and clamped temperature
`timescale 1ns / 1ps
module hpt_temp
   import hpt_pkg::*;
(
   input  logic               clock,
   input  logic               en,
   input  logic [47:0]        temp_calib,
   input  logic [19:0]        raw_temperature,
   input  logic [19:0]        raw_pressure,
   input  logic [15:0]        raw_humidity,
   output logic signed [31:0] tfine,
   output logic [19:0]        rp_out,
   output logic [15:0]        rh_out,
   output logic signed [14:0] temp_out
);

   logic signed [31:0] t1, t2, t3;
   logic signed [31:0] a0_ff, b0_ff, am_ff, bb_ff, a1_ff, bq_ff, a2_ff, bm_ff, tfine_ff;
   logic signed [31:0] temp_in;
   logic signed [14:0] temp_ff;
   logic [19:0] rp_ff [TFINE_LAT];
   logic [15:0] rh_ff [TFINE_LAT];

   assign t1 = $signed({16'd0, temp_calib[15:0]});
   assign t2 = sx16(temp_calib[31:16]);
   assign t3 = sx16(temp_calib[47:32]);

   always_comb begin
      temp_in = sdiv_p2(tfine_ff * 32'sd5 + 32'sd128, 8);
      if (temp_in < TEMP_MIN) begin
         temp_in = TEMP_MIN;
      end else if (temp_in > TEMP_MAX) begin
         temp_in = TEMP_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a0_ff <= $signed({12'd0, raw_temperature} >> 3) - (t1 <<< 1);
         b0_ff <= $signed({12'd0, raw_temperature} >> 4) - t1;
         am_ff <= a0_ff * t2;
         bb_ff <= b0_ff * b0_ff;
         a1_ff <= sdiv_p2(am_ff, 11);
         bq_ff <= sdiv_p2(bb_ff, 12);
         a2_ff <= a1_ff;
         bm_ff <= bq_ff * t3;
         tfine_ff <= a2_ff + sdiv_p2(bm_ff, 14);
         temp_ff <= temp_in[14:0];
         rp_ff[0] <= raw_pressure;
         rh_ff[0] <= raw_humidity;
         for (int i = 1; i < TFINE_LAT; i++) begin
            rp_ff[i] <= rp_ff[i-1];
            rh_ff[i] <= rh_ff[i-1];
         end
      end
   end

   assign tfine = tfine_ff;
   assign temp_out = temp_ff;
   assign rp_out = rp_ff[TFINE_LAT-1];
   assign rh_out = rh_ff[TFINE_LAT-1];

endmodule

// ===== rtl/hpt_div.sv =====
// Pipelined unsigned restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
module hpt_div
   import hpt_pkg::*;
(
   input  logic        clock,
   input  logic        en,
   input  logic [31:0] num,
   input  logic [31:0] den,
   input  logic        dbl,
   input  logic        zero,
   output logic [31:0] quo,
   output logic        dbl_out,
   output logic        zero_out
);

   logic [31:0] rem_ff [DIV_BITS];
   logic [31:0] quo_ff [DIV_BITS];
   logic [31:0] num_ff [DIV_BITS];
   logic [31:0] den_ff [DIV_BITS];
   logic        dbl_ff [DIV_BITS];
   logic        zero_ff [DIV_BITS];
   logic [31:0] rem_src [DIV_BITS];
   logic [31:0] quo_src [DIV_BITS];
   logic [31:0] num_src [DIV_BITS];
   logic [31:0] den_src [DIV_BITS];
   logic [32:0] sh [DIV_BITS];
   logic [32:0] diff [DIV_BITS];
   logic [31:0] rem_in [DIV_BITS];
   logic [31:0] quo_in [DIV_BITS];

   always_comb begin
      rem_src[0] = '0;
      quo_src[0] = '0;
      num_src[0] = num;
      den_src[0] = den;
      for (int i = 1; i < DIV_BITS; i++) begin
         rem_src[i] = rem_ff[i-1];
         quo_src[i] = quo_ff[i-1];
         num_src[i] = num_ff[i-1];
         den_src[i] = den_ff[i-1];
      end
      for (int i = 0; i < DIV_BITS; i++) begin
         sh[i] = {rem_src[i], num_src[i][31]};
         diff[i] = sh[i] - {1'b0, den_src[i]};
         if (!diff[i][32]) begin
            rem_in[i] = diff[i][31:0];
            quo_in[i] = {quo_src[i][30:0], 1'b1};
         end else begin
            rem_in[i] = sh[i][31:0];
            quo_in[i] = {quo_src[i][30:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dbl_ff[0] <= dbl;
         zero_ff[0] <= zero;
         for (int i = 0; i < DIV_BITS; i++) begin
            rem_ff[i] <= rem_in[i];
            quo_ff[i] <= quo_in[i];
            num_ff[i] <= num_src[i] << 1;
            den_ff[i] <= den_src[i];
         end
         for (int i = 1; i < DIV_BITS; i++) begin
            dbl_ff[i] <= dbl_ff[i-1];
            zero_ff[i] <= zero_ff[i-1];
         end
      end
   end

   assign quo = quo_ff[DIV_BITS-1];
   assign dbl_out = dbl_ff[DIV_BITS-1];
   assign zero_out = zero_ff[DIV_BITS-1];

endmodule

// ===== rtl/hpt_press.sv =====
// Pressure path: divisor and dividend, long division, final correction and clamp
`timescale 1ns / 1ps
module hpt_press
   import hpt_pkg::*;
(
   input  logic               clock,
   input  logic               en,
   input  logic [63:0]        press_calib_low,
   input  logic [63:0]        press_calib_high,
   input  logic [15:0]        press_calib_last,
   input  logic signed [31:0] tfine,
   input  logic [19:0]        raw_pressure,
   output logic [16:0]        pressure_out
);

   logic signed [31:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
   logic signed [31:0] a_in;
   logic signed [31:0] a1_ff, a41_ff, a2_ff, sq_ff, ap5_ff, a3_ff, s1_ff, s2_ff, ap5x2_ff;
   logic signed [31:0] m6_ff, m3_ff, md_ff, b4_ff, b5_ff, x5_ff, xm_ff, b6_ff, dv7_ff, dv8_ff;
   logic signed [31:0] b5_in, e5_in;
   logic [31:0] pr7_ff, prm_ff;
   logic [19:0] rp_ff [6];
   logic [31:0] num, quo, pr_q, qq_ff, pr1_ff, pr2_ff, pr3_in;
   logic signed [31:0] c2_ff, d2_ff, e3_in;
   logic        dbl, zero, dbl_q, zero_q, zero1_ff, zero2_ff;
   logic [16:0] press_ff;

   assign p1 = $signed({16'd0, press_calib_low[15:0]});
   assign p2 = sx16(press_calib_low[31:16]);
   assign p3 = sx16(press_calib_low[47:32]);
   assign p4 = sx16(press_calib_low[63:48]);
   assign p5 = sx16(press_calib_high[15:0]);
   assign p6 = sx16(press_calib_high[31:16]);
   assign p7 = sx16(press_calib_high[47:32]);
   assign p8 = sx16(press_calib_high[63:48]);
   assign p9 = sx16(press_calib_last);

   assign a_in = sdiv_p2(tfine, 1) - 32'sd64000;
   assign b5_in = sdiv_p2(m6_ff + b4_ff, 2) + (p4 <<< 16);
   assign e5_in = sdiv_p2(sdiv_p2(m3_ff, 3) + sdiv_p2(md_ff, 1), 18);

   always_comb begin
      if (prm_ff < 32'h8000_0000) begin
         num = prm_ff << 1;
         dbl = 1'b0;
      end else begin
         num = prm_ff;
         dbl = 1'b1;
      end
      zero = (dv8_ff == 32'sd0);
   end

   hpt_div u_div (
      .clock    (clock),
      .en       (en),
      .num      (num),
      .den      (dv8_ff),
      .dbl      (dbl),
      .zero     (zero),
      .quo      (quo),
      .dbl_out  (dbl_q),
      .zero_out (zero_q)
   );

   assign pr_q = dbl_q ? {quo[30:0], 1'b0} : quo;

   always_comb begin
      e3_in = sdiv_p2(sdiv_p2(c2_ff, 12) + sdiv_p2(d2_ff, 13) + p7, 4);
      pr3_in = pr2_ff + e3_in;
      if (zero2_ff || pr3_in < PRESS_MIN) begin
         pr3_in = PRESS_MIN;
      end else if (pr3_in > PRESS_MAX) begin
         pr3_in = PRESS_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a1_ff <= a_in;
         a41_ff <= sdiv_p2(a_in, 2);
         sq_ff <= a41_ff * a41_ff;
         ap5_ff <= a1_ff * p5;
         a2_ff <= a1_ff;
         s1_ff <= sdiv_p2(sq_ff, 11);
         s2_ff <= sdiv_p2(sq_ff, 13);
         ap5x2_ff <= ap5_ff <<< 1;
         a3_ff <= a2_ff;
         m6_ff <= s1_ff * p6;
         m3_ff <= p3 * s2_ff;
         md_ff <= p2 * a3_ff;
         b4_ff <= ap5x2_ff;
         b5_ff <= b5_in;
         x5_ff <= 32'sd32768 + e5_in;
         xm_ff <= x5_ff * p1;
         b6_ff <= b5_ff;
         dv7_ff <= sdiv_p2(xm_ff, 15);
         pr7_ff <= (32'd1048576 - {12'd0, rp_ff[5]}) - sdiv_p2(b6_ff, 12);
         prm_ff <= pr7_ff * 32'd3125;
         dv8_ff <= dv7_ff;
         rp_ff[0] <= raw_pressure;
         for (int i = 1; i < 6; i++) begin
            rp_ff[i] <= rp_ff[i-1];
         end
         qq_ff <= (pr_q >> 3) * (pr_q >> 3);
         pr1_ff <= pr_q;
         zero1_ff <= zero_q;
         c2_ff <= p9 * $signed(qq_ff >> 13);
         d2_ff <= $signed(pr1_ff >> 2) * p8;
         pr2_ff <= pr1_ff;
         zero2_ff <= zero1_ff;
         press_ff <= pr3_in[16:0];
      end
   end

   assign pressure_out = press_ff;

endmodule

// ===== rtl/hpt_hum.sv =====
// Humidity path: compensation chain and clamp
`timescale 1ns / 1ps
module hpt_hum
   import hpt_pkg::*;
(
   input  logic               clock,
   input  logic               en,
   input  logic [63:0]        hum_calib,
   input  logic signed [31:0] tfine,
   input  logic [15:0]        raw_humidity,
   output logic [16:0]        humidity_out
);

   logic signed [31:0] h1, h2, h3, h4, h5, h6;
   logic signed [31:0] a1_ff, b1_ff, d2_ff, m6_ff, m3_ff, b2_ff;
   logic signed [31:0] e3_ff, bb3_ff, cc3_ff, e4_ff, m4_ff, e5_ff, dd5_ff, e6_ff, e7_ff, m6b_ff;
   logic signed [31:0] b7_ff, c8_ff, sq9_ff, c9_ff, d10_ff, c10_ff, m11_ff, c11_ff, e12_in;
   logic [16:0] hum_ff;

   assign h1 = $signed({24'd0, hum_calib[7:0]});
   assign h2 = sx16(hum_calib[23:8]);
   assign h3 = $signed({24'd0, hum_calib[31:24]});
   assign h4 = sx12(hum_calib[43:32]);
   assign h5 = sx12(hum_calib[55:44]);
   assign h6 = sx8(hum_calib[63:56]);

   always_comb begin
      e12_in = c11_ff - sdiv_p2(m11_ff, 4);
      if (e12_in < 32'sd0) begin
         e12_in = 32'sd0;
      end else if (e12_in > HUM_E_MAX) begin
         e12_in = HUM_E_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a1_ff <= tfine - 32'sd76800;
         b1_ff <= $signed({2'd0, raw_humidity, 14'd0}) - (h4 <<< 20);
         d2_ff <= h5 * a1_ff;
         m6_ff <= a1_ff * h6;
         m3_ff <= a1_ff * h3;
         b2_ff <= b1_ff;
         e3_ff <= sdiv_p2(b2_ff - d2_ff + 32'sd16384, 15);
         bb3_ff <= sdiv_p2(m6_ff, 10);
         cc3_ff <= sdiv_p2(m3_ff, 11) + 32'sd32768;
         m4_ff <= bb3_ff * cc3_ff;
         e4_ff <= e3_ff;
         dd5_ff <= sdiv_p2(m4_ff, 10) + 32'sd2097152;
         e5_ff <= e4_ff;
         m6b_ff <= dd5_ff * h2;
         e6_ff <= e5_ff;
         b7_ff <= sdiv_p2(m6b_ff + 32'sd8192, 14);
         e7_ff <= e6_ff;
         c8_ff <= e7_ff * b7_ff;
         sq9_ff <= sdiv_p2(c8_ff, 15) * sdiv_p2(c8_ff, 15);
         c9_ff <= c8_ff;
         d10_ff <= sdiv_p2(sq9_ff, 7);
         c10_ff <= c9_ff;
         m11_ff <= d10_ff * h1;
         c11_ff <= c10_ff;
         hum_ff <= e12_in[28:12];
      end
   end

   assign humidity_out = hum_ff;

endmodule
